[src/bmw_pkg.sv]
// shared types and constants of the block map walker
package bmw_pkg;

  localparam int BLOCK_W  = 32;
  localparam int INDEX_W  = 10;
  localparam int LBN_W    = 36;
  localparam int SLOT_W   = 4;
  localparam int RESID_W  = 20;
  localparam int SHIFT_W  = 5;
  localparam int LOG_W    = 2;

  localparam logic [BLOCK_W-1:0] INVALID_BLOCK = '1;
  localparam logic [LOG_W-1:0]   LOG_MAX       = 2'd2;
  localparam logic [SHIFT_W-1:0] BASE_SHIFT    = 5'd8;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [1:0] LEVEL_LAST   = 2'd0;
  localparam logic [1:0] LEVEL_MIDDLE = 2'd1;
  localparam logic [1:0] LEVEL_TOP    = 2'd2;

  typedef enum logic [1:0] {
    MODE_LOAD      = 2'd0,
    MODE_TRANSLATE = 2'd1,
    MODE_RESPONSE  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_READ_FAIL = 2'd2
  } status_t;

  typedef struct packed {
    logic                use_ram;
    logic                kind;
    logic [BLOCK_W-1:0]  addr;
    logic [INDEX_W-1:0]  idx;
    status_t             status;
  } pend_t;

endpackage

[src/block_map_walker_top.sv]
// top level of the block map walker: pointer memory, walk state and output stage
//
// Translates a file's logical block number into a disk block number through an
// ext2-style block map. Mode 0 items load the inode pointers into a small
// pointer memory, mode 1 items translate a logical block, mode 2 items carry
// the words returned for the read requests the block issues during a walk.
// Every item is taken on its handshake; its result, if any, passes through the
// registered read of the pointer memory, held beside the pending register, and
// then through the output register. With the output taken every cycle, one item
// per cycle is sustained. Translations arriving during a walk, responses
// arriving while idle and mode 3 items give no result.
module block_map_walker_top
  import bmw_pkg::*;
#(
  parameter int DIRECT_POINTERS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,   // log_block_size
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,    // slot, logical_block, word, read_failed, zero pad
  input  logic [1:0]  s_tuser,    // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // block_address, word_index, status, zero pad
  output logic        m_tuser     // kind
);

  localparam int TABLE_DEPTH = DIRECT_POINTERS + 3;
  localparam int AW          = $clog2(TABLE_DEPTH);

  logic [LOG_W-1:0]   log_block_size;
  logic               walk_busy, walk_busy_next;
  logic [1:0]         walk_level, walk_level_next;
  logic [RESID_W-1:0] residual, residual_next;
  logic               pend_valid, pend_valid_next;
  pend_t              pend, pend_next;
  logic               out_valid;
  pend_t              out_item;
  logic [BLOCK_W-1:0] out_addr;

  logic [SLOT_W-1:0]  in_slot;
  logic [LBN_W-1:0]   in_lbn;
  logic [BLOCK_W-1:0] in_word;
  logic               in_failed;
  mode_t              in_mode;

  logic               s_fire, pend_move;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [BLOCK_W-1:0] ram_rdata;

  logic [LOG_W-1:0]   lg;
  logic [SHIFT_W-1:0] s1, s2, s3;
  logic [LBN_W-1:0]   base1, base2, base3, limit;
  logic [LBN_W-1:0]   r1, r2, r3;
  logic [LBN_W-1:0]   emask, emask2;

  assign in_slot   = s_tdata[3:0];
  assign in_lbn    = s_tdata[39:4];
  assign in_word   = s_tdata[71:40];
  assign in_failed = s_tdata[72];
  assign in_mode   = mode_t'(s_tuser);

  assign pend_move = pend_valid && (!out_valid || m_tready);
  assign s_tready  = !pend_valid || pend_move;
  assign s_fire    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_block_size <= '0;
    end else if (cfg_we) begin
      log_block_size <= cfg_data;
    end
  end

  // block geometry
  always_comb begin
    lg     = (log_block_size > LOG_MAX) ? LOG_MAX : log_block_size;
    s1     = BASE_SHIFT + SHIFT_W'(lg);
    s2     = SHIFT_W'({s1, 1'b0});
    s3     = s2 + s1;
    emask  = (LBN_W'(1) << s1) - LBN_W'(1);
    emask2 = (LBN_W'(1) << s2) - LBN_W'(1);
    base1  = LBN_W'(DIRECT_POINTERS);
    base2  = base1 + (LBN_W'(1) << s1);
    base3  = base2 + (LBN_W'(1) << s2);
    limit  = base3 + (LBN_W'(1) << s3);
    r1     = in_lbn - base1;
    r2     = in_lbn - base2;
    r3     = in_lbn - base3;
  end

  assign ram_we = s_fire && (in_mode == MODE_LOAD) && (32'(in_slot) < TABLE_DEPTH);
  assign ram_re = s_fire;

  bmw_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (TABLE_DEPTH)
  ) u_pointer_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_slot)),
    .wdata (in_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    walk_busy_next  = walk_busy;
    walk_level_next = walk_level;
    residual_next   = residual;
    pend_valid_next = pend_valid && !pend_move;
    pend_next       = pend;
    ram_raddr       = AW'(in_lbn);
    if (s_fire) begin
      pend_next.use_ram = 1'b0;
      pend_next.kind    = KIND_DONE;
      pend_next.addr    = INVALID_BLOCK;
      pend_next.idx     = '0;
      pend_next.status  = STATUS_OK;
      pend_valid_next   = 1'b0;
      unique case (in_mode)
        MODE_TRANSLATE: begin
          if (!walk_busy) begin
            pend_valid_next = 1'b1;
            if (in_lbn < base1) begin
              pend_next.use_ram = 1'b1;
            end else if (in_lbn < base2) begin
              ram_raddr         = AW'(DIRECT_POINTERS);
              pend_next.use_ram = 1'b1;
              pend_next.kind    = KIND_READ;
              pend_next.idx     = INDEX_W'(r1);
              walk_busy_next    = 1'b1;
              walk_level_next   = LEVEL_LAST;
              residual_next     = '0;
            end else if (in_lbn < base3) begin
              ram_raddr         = AW'(DIRECT_POINTERS + 1);
              pend_next.use_ram = 1'b1;
              pend_next.kind    = KIND_READ;
              pend_next.idx     = INDEX_W'(r2 >> s1);
              walk_busy_next    = 1'b1;
              walk_level_next   = LEVEL_MIDDLE;
              residual_next     = RESID_W'(r2 & emask);
            end else if (in_lbn < limit) begin
              ram_raddr         = AW'(DIRECT_POINTERS + 2);
              pend_next.use_ram = 1'b1;
              pend_next.kind    = KIND_READ;
              pend_next.idx     = INDEX_W'(r3 >> s2);
              walk_busy_next    = 1'b1;
              walk_level_next   = LEVEL_TOP;
              residual_next     = RESID_W'(r3 & emask2);
            end else begin
              pend_next.status = STATUS_RANGE;
            end
          end
        end
        MODE_RESPONSE: begin
          if (walk_busy) begin
            pend_valid_next = 1'b1;
            if (in_failed) begin
              pend_next.status = STATUS_READ_FAIL;
              walk_busy_next   = 1'b0;
              walk_level_next  = LEVEL_LAST;
              residual_next    = '0;
            end else if (walk_level == LEVEL_LAST) begin
              pend_next.addr = in_word;
              walk_busy_next = 1'b0;
              residual_next  = '0;
            end else if (walk_level == LEVEL_TOP) begin
              pend_next.kind  = KIND_READ;
              pend_next.addr  = in_word;
              pend_next.idx   = INDEX_W'(residual >> s1);
              residual_next   = residual & RESID_W'(emask);
              walk_level_next = LEVEL_MIDDLE;
            end else begin
              pend_next.kind  = KIND_READ;
              pend_next.addr  = in_word;
              pend_next.idx   = INDEX_W'(residual & RESID_W'(emask));
              residual_next   = '0;
              walk_level_next = LEVEL_LAST;
            end
          end
        end
        default: begin
          pend_valid_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_busy  <= 1'b0;
      walk_level <= LEVEL_LAST;
      residual   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      walk_busy  <= walk_busy_next;
      walk_level <= walk_level_next;
      residual   <= residual_next;
      pend_valid <= pend_valid_next;
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      pend <= pend_next;
    end
    if (pend_move) begin
      out_item <= pend;
      out_addr <= pend.use_ram ? ram_rdata : pend.addr;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_item.kind;
  assign m_tdata  = {4'd0, out_item.status, out_item.idx, out_addr};

endmodule

[src/bmw_ram.sv]
// generic single write port, single read port ram with registered read
module bmw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/walk_checker.sv]
// checker for the block map walker: watches both item channels, predicts and compares results
`timescale 1ns / 100ps

module walk_checker
  import bmw_pkg::*;
#(
  parameter int DIRECT = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,    // slot, logical_block, word, read_failed, zero pad
  input  logic [1:0]  s_tuser,    // mode
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,    // block_address, word_index, status, zero pad
  input  logic        m_tuser,    // kind
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic               kind;
    logic [BLOCK_W-1:0] addr;
    logic [INDEX_W-1:0] idx;
    status_t            status;
  } map_result_t;

  logic [BLOCK_W-1:0] ptr_tab [0:DIRECT+2];
  logic [1:0]         level;
  logic [LBN_W-1:0]   resid;
  logic               busy;
  logic [LOG_W-1:0]   log_bs;
  map_result_t        expected_lookups[$];
  int                 err_count;

  function automatic bit predict_translation(input logic [1:0] md, input logic [SLOT_W-1:0] sl,
                                             input logic [LBN_W-1:0] lbn,
                                             input logic [BLOCK_W-1:0] wd, input logic fl,
                                             output map_result_t res);
    logic [LOG_W-1:0] lgs;
    int               s;
    logic [63:0]      e, emask, b2, b3, lim, r;
    bit               hit;
    hit = 1'b0;
    res.kind = KIND_DONE;
    res.addr = '0;
    res.idx = '0;
    res.status = STATUS_OK;
    lgs = (log_bs > LOG_MAX) ? LOG_MAX : log_bs;
    s = int'(BASE_SHIFT) + int'(lgs);
    e = 64'd1 << s;
    emask = e - 64'd1;
    b2 = 64'(DIRECT) + e;
    b3 = b2 + (e << s);
    lim = b3 + (e << (2 * s));
    case (md)
      MODE_LOAD: if (sl < DIRECT + 3) ptr_tab[sl] = wd;
      MODE_TRANSLATE: if (!busy) begin
        hit = 1'b1;
        if (lbn < DIRECT) begin
          res.addr = ptr_tab[lbn[SLOT_W-1:0]];
        end else if (lbn < b2) begin
          r = 64'(lbn) - 64'(DIRECT);
          res.kind = KIND_READ;
          res.addr = ptr_tab[DIRECT];
          res.idx = r[INDEX_W-1:0];
          level = LEVEL_LAST;
          resid = '0;
          busy = 1'b1;
        end else if (lbn < b3) begin
          r = 64'(lbn) - b2;
          res.kind = KIND_READ;
          res.addr = ptr_tab[DIRECT+1];
          res.idx = INDEX_W'(r >> s);
          level = LEVEL_MIDDLE;
          resid = LBN_W'(r & emask);
          busy = 1'b1;
        end else if (lbn < lim) begin
          r = 64'(lbn) - b3;
          res.kind = KIND_READ;
          res.addr = ptr_tab[DIRECT+2];
          res.idx = INDEX_W'(r >> (2 * s));
          level = LEVEL_TOP;
          resid = LBN_W'(r & ((e << s) - 64'd1));
          busy = 1'b1;
        end else begin
          res.addr = INVALID_BLOCK;
          res.status = STATUS_RANGE;
        end
      end
      MODE_RESPONSE: if (busy) begin
        hit = 1'b1;
        if (fl) begin
          busy = 1'b0;
          level = LEVEL_LAST;
          resid = '0;
          res.addr = INVALID_BLOCK;
          res.status = STATUS_READ_FAIL;
        end else if (level == LEVEL_LAST) begin
          busy = 1'b0;
          resid = '0;
          res.addr = wd;
        end else begin
          res.kind = KIND_READ;
          res.addr = wd;
          r = 64'(resid);
          if (level == LEVEL_TOP) begin
            resid = LBN_W'(r & emask);
            r = r >> s;
            level = LEVEL_MIDDLE;
          end else begin
            r = r & emask;
            resid = '0;
            level = LEVEL_LAST;
          end
          res.idx = r[INDEX_W-1:0];
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  always @(posedge clk) begin
    map_result_t got, want;
    if (rst) begin
      for (int i = 0; i <= DIRECT + 2; i++) ptr_tab[i] = '0;
      level = LEVEL_LAST;
      resid = '0;
      busy = 1'b0;
      log_bs = '0;
      expected_lookups.delete();
      err_count = 0;
    end else begin
      if (cfg_we) log_bs = cfg_data;
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.addr = m_tdata[31:0];
        got.idx = m_tdata[41:32];
        got.status = status_t'(m_tdata[43:42]);
        if (expected_lookups.size() == 0) begin
          $error("unexpected result: kind %0d block_address %h word_index %0d status %0d",
                 got.kind, got.addr, got.idx, got.status);
          err_count++;
        end else begin
          want = expected_lookups.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            err_count++;
          end
          if (got.addr !== want.addr) begin
            $error("block_address: expected %h, got %h", want.addr, got.addr);
            err_count++;
          end
          if (got.idx !== want.idx) begin
            $error("word_index: expected %0d, got %0d", want.idx, got.idx);
            err_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            err_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (predict_translation(s_tuser, s_tdata[3:0], s_tdata[39:4], s_tdata[71:40],
                                s_tdata[72], want))
          expected_lookups.push_back(want);
      end
    end
    errors <= err_count;
    pending <= expected_lookups.size();
  end

endmodule

[tb/tb.sv]
// testbench top for the block map walker: clock, reset, stimulus phases and verdict
`timescale 1ns / 100ps

module tb;
  import bmw_pkg::*;

  localparam int         N_DIRECT     = 12;
  localparam int         PER_PHASE    = 185;
  localparam int         LIMIT_CYCLES = 300000;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;      // slot, logical_block, word, read_failed, zero pad
  logic [1:0]  s_tuser = '0;      // mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;           // block_address, word_index, status, zero pad
  logic        m_tuser;           // kind
  int          errors;
  int          pending;

  int               idle_pct = 0;
  int               stall_pct = 0;
  int               item_count = 0;
  int               cycles = 0;
  logic [LOG_W-1:0] eff_log = '0;

  int         idle_tab [4] = '{0, 50, 0, 36};
  int         stall_tab [4] = '{0, 0, 50, 36};
  logic [1:0] cfg_tab [8] = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd2, 2'd0, 2'd1, 2'd2};

  block_map_walker_top #(.DIRECT_POINTERS(N_DIRECT)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  walk_checker #(.DIRECT(N_DIRECT)) chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // first logical block of level k (k = 4 gives the end of the triple range)
  function automatic longint unsigned range_base(input int k);
    longint unsigned e, pw, b;
    e = 64'd256 << eff_log;
    pw = e;
    b = 64'(N_DIRECT);
    for (int i = 1; i < k; i++) begin
      b += pw;
      pw *= e;
    end
    return b;
  endfunction

  // class 0 direct, 1..3 indirect depth, 4 out of range
  function automatic logic [LBN_W-1:0] pick_lbn(input int cls);
    longint unsigned lo, span, v;
    lo = (cls == 0) ? 64'd0 : range_base(cls);
    if (cls >= 4) begin
      case ($urandom_range(2))
        0: v = lo;
        1: v = lo + 64'($urandom_range(0, 1000));
        default: v = {$urandom_range(1, 15), $urandom};
      endcase
    end else begin
      span = range_base(cls + 1) - lo;
      case ($urandom_range(7))
        0: v = lo;
        1: v = lo + span - 1;
        default: v = lo + ($urandom % span);
      endcase
    end
    return v[LBN_W-1:0];
  endfunction

  function automatic logic [BLOCK_W-1:0] rnd_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SLOT_W-1:0] rnd_slot(input int top);
    return SLOT_W'($urandom_range(top));
  endfunction

  function automatic logic rnd_flag();
    return 1'($urandom_range(1));
  endfunction

  task automatic put_item(input logic [1:0] md, input logic [SLOT_W-1:0] sl,
                          input logic [LBN_W-1:0] lbn, input logic [BLOCK_W-1:0] wd,
                          input logic fl, input bit counts);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= md;
    s_tdata <= {7'd0, fl, wd, lbn, sl};
    do @(posedge clk); while (!s_tready);
    if (counts) item_count++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_walk(input int depth);
    bit fail;
    put_item(MODE_TRANSLATE, rnd_slot(15), pick_lbn(depth), rnd_word(), rnd_flag(), 1);
    for (int lv = 0; lv < depth; lv++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0: put_item(MODE_TRANSLATE, rnd_slot(15), pick_lbn($urandom_range(4)),
                      rnd_word(), rnd_flag(), 0);
          1: put_item(MODE_LOAD, rnd_slot(N_DIRECT + 2), pick_lbn(4), rnd_word(),
                      rnd_flag(), 1);
          default: put_item(MODE_UNUSED, rnd_slot(15), pick_lbn(4), rnd_word(),
                            rnd_flag(), 0);
        endcase
      end
      fail = ($urandom_range(15) == 0);
      put_item(MODE_RESPONSE, rnd_slot(15), pick_lbn($urandom_range(4)), rnd_word(),
               fail, 1);
      if (fail) break;
    end
  endtask

  initial begin
    int pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // pointers first, then every kind of lookup at least once
    for (int i = 0; i < N_DIRECT + 3; i++)
      put_item(MODE_LOAD, SLOT_W'(i), LBN_W'($urandom),
               (i == 0) ? '0 : (i == 1) ? '1 : $urandom, i[0], 1);
    put_item(MODE_LOAD, 4'd15, '1, '1, 1'b1, 0);
    put_item(MODE_TRANSLATE, 4'd0, '0, '0, 1'b0, 1);
    put_item(MODE_TRANSLATE, 4'd0, LBN_W'(N_DIRECT - 1), '0, 1'b0, 1);
    put_item(MODE_TRANSLATE, 4'd0, LBN_W'(range_base(1)), '0, 1'b0, 1);
    put_item(MODE_RESPONSE, 4'd0, '0, '0, 1'b0, 1);
    put_item(MODE_RESPONSE, 4'd15, '1, '1, 1'b0, 0);
    put_item(MODE_UNUSED, 4'd15, '1, '1, 1'b1, 0);
    put_item(MODE_TRANSLATE, 4'd15, '1, '1, 1'b1, 1);
    put_item(MODE_TRANSLATE, 4'd0, LBN_W'(range_base(4) - 1), '0, 1'b0, 1);
    put_item(MODE_RESPONSE, 4'd0, '0, '1, 1'b0, 1);
    put_item(MODE_RESPONSE, 4'd0, '0, $urandom, 1'b1, 1);
    put_item(MODE_TRANSLATE, 4'd0, LBN_W'(range_base(2)), '0, 1'b0, 1);
    put_item(MODE_TRANSLATE, 4'd0, '0, '0, 1'b0, 0);
    put_item(MODE_RESPONSE, 4'd0, '0, $urandom, 1'b0, 1);
    put_item(MODE_RESPONSE, 4'd0, '0, $urandom, 1'b0, 1);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_we <= 1'b1;
      cfg_data <= cfg_tab[ph];
      stall_pct <= stall_tab[ph % 4];
      idle_pct = idle_tab[ph % 4];
      @(posedge clk);
      cfg_we <= 1'b0;
      eff_log = (cfg_tab[ph] > LOG_MAX) ? LOG_MAX : cfg_tab[ph];
      item_count = 0;
      while (item_count < PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 12)
          put_item(MODE_LOAD, rnd_slot(N_DIRECT + 2), pick_lbn(4), rnd_word(),
                   rnd_flag(), 1);
        else if (pick < 22)
          put_item(MODE_TRANSLATE, rnd_slot(15), pick_lbn(0), rnd_word(), rnd_flag(), 1);
        else if (pick < 30)
          put_item(MODE_TRANSLATE, rnd_slot(15), pick_lbn(4), rnd_word(), rnd_flag(), 1);
        else if (pick < 88)
          run_walk($urandom_range(1, 3));
        else if (pick < 92)
          put_item(MODE_RESPONSE, rnd_slot(15), pick_lbn($urandom_range(4)),
                   rnd_word(), rnd_flag(), 0);
        else if (pick < 96)
          put_item(MODE_UNUSED, rnd_slot(15), pick_lbn($urandom_range(4)),
                   rnd_word(), rnd_flag(), 0);
        else
          put_item(MODE_LOAD, 4'd15, pick_lbn(4), rnd_word(), rnd_flag(), 0);
      end
      settle();
    end

    if (errors == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
